[design/rbc_pkg.sv]
package rbc_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int BOUND_W     = 64;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int COUNT_W     = 3;
   localparam int LABEL_W     = 2;
   localparam int PROD_W      = 2 * SAMPLE_W;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_REGIME_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLEND_MODE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUNDS_0     = 3'd2;

   // per-beat side information carried alongside the datapath
   typedef struct packed {
      logic [LABEL_W-1:0] label;     // segment regime, or lower neighbor in a gap
      logic               gap;       // sample lies in a gap
      logic               quad;      // two-piece quadratic weighting
      logic               low_half;  // gap offset at or below the midpoint
   } rbc_meta_type;

endpackage

[design/rbc_classify.sv]
module rbc_classify #(
   parameter int MAX_REGIMES = 4
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic [rbc_pkg::COUNT_W-1:0]                    regime_count,
   input  logic [MAX_REGIMES-1:0][rbc_pkg::BOUND_W-1:0]   regime_bounds,
   input  logic                                           in_valid,
   output logic                                           in_ready,
   input  logic signed [rbc_pkg::SAMPLE_W-1:0]            in_sample,
   output logic                                           out_valid,
   input  logic                                           out_ready,
   output rbc_pkg::rbc_meta_type                          out_meta,
   output logic [rbc_pkg::SAMPLE_W-1:0]                   out_width,
   output logic [rbc_pkg::SAMPLE_W-1:0]                   out_offset
);
   import rbc_pkg::*;

   localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(MAX_REGIMES);

   logic [COUNT_W-1:0]         used_n;
   rbc_meta_type               sel_meta;
   logic signed [SAMPLE_W-1:0] sel_start;
   logic signed [SAMPLE_W-1:0] sel_end;

   logic                       a_valid_ff;
   rbc_meta_type               a_meta_ff;
   logic signed [SAMPLE_W-1:0] a_sample_ff;
   logic signed [SAMPLE_W-1:0] a_start_ff;
   logic signed [SAMPLE_W-1:0] a_end_ff;
   logic                       b_valid_ff;
   rbc_meta_type               b_meta_ff;
   logic [SAMPLE_W-1:0]        b_width_ff;
   logic [SAMPLE_W-1:0]        b_offset_ff;
   logic                       adv_a;
   logic                       adv_b;

   assign used_n = (regime_count == '0)   ? COUNT_W'(1) :
                   (regime_count > MAX_N) ? MAX_N : regime_count;

   // last segment start not above the sample wins
   always_comb begin
      logic signed [SAMPLE_W-1:0] ub;
      logic signed [SAMPLE_W-1:0] lb;
      sel_meta  = '0;
      sel_start = '0;
      sel_end   = '0;
      for (int i = 1; i < MAX_REGIMES; i++) begin
         ub = signed'(regime_bounds[i-1][BOUND_W-1:SAMPLE_W]);
         lb = signed'(regime_bounds[i][SAMPLE_W-1:0]);
         if (COUNT_W'(i) < used_n) begin
            if ((ub < lb) && (in_sample >= ub)) begin
               sel_meta.gap   = 1'b1;
               sel_meta.label = LABEL_W'(i - 1);
               sel_start      = ub;
               sel_end        = lb;
            end
            if (in_sample >= lb) begin
               sel_meta.gap   = 1'b0;
               sel_meta.label = LABEL_W'(i);
            end
         end
      end
   end

   assign adv_b    = !b_valid_ff || out_ready;
   assign adv_a    = !a_valid_ff || adv_b;
   assign in_ready = adv_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (adv_a) a_valid_ff <= in_valid;
         if (adv_b) b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a) begin
         a_meta_ff   <= sel_meta;
         a_sample_ff <= in_sample;
         a_start_ff  <= sel_start;
         a_end_ff    <= sel_end;
      end
      if (adv_b) begin
         b_meta_ff   <= a_meta_ff;
         b_width_ff  <= SAMPLE_W'(a_end_ff - a_start_ff);
         b_offset_ff <= SAMPLE_W'(a_sample_ff - a_start_ff);
      end
   end

   assign out_valid  = b_valid_ff;
   assign out_meta   = b_meta_ff;
   assign out_width  = b_width_ff;
   assign out_offset = b_offset_ff;

endmodule

[design/rbc_shape.sv]
module rbc_shape (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           blend_mode,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  rbc_pkg::rbc_meta_type          in_meta,
   input  logic [rbc_pkg::SAMPLE_W-1:0]   in_width,
   input  logic [rbc_pkg::SAMPLE_W-1:0]   in_offset,
   output logic                           out_valid,
   input  logic                           out_ready,
   output rbc_pkg::rbc_meta_type          out_meta,
   output logic [rbc_pkg::PROD_W-1:0]     out_num,
   output logic [rbc_pkg::PROD_W-1:0]     out_den
);
   import rbc_pkg::*;

   logic [SAMPLE_W-1:0] rest;
   logic                low_half;
   rbc_meta_type        c_meta_in;

   logic                c_valid_ff;
   rbc_meta_type        c_meta_ff;
   logic [SAMPLE_W-1:0] c_width_ff;
   logic [SAMPLE_W-1:0] c_offset_ff;
   logic [SAMPLE_W-1:0] c_side_ff;
   logic                d_valid_ff;
   rbc_meta_type        d_meta_ff;
   logic [PROD_W-1:0]   d_num_ff;
   logic [PROD_W-1:0]   d_den_ff;
   logic [PROD_W-1:0]   side_sq;
   logic [PROD_W-1:0]   width_sq;
   logic                adv_c;
   logic                adv_d;

   assign rest     = in_width - in_offset;
   assign low_half = {in_offset, 1'b0} <= {1'b0, in_width};

   always_comb begin
      c_meta_in          = in_meta;
      c_meta_in.quad     = blend_mode;
      c_meta_in.low_half = low_half;
   end

   assign side_sq  = c_side_ff * c_side_ff;
   assign width_sq = c_width_ff * c_width_ff;

   assign adv_d    = !d_valid_ff || out_ready;
   assign adv_c    = !c_valid_ff || adv_d;
   assign in_ready = adv_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (adv_c) c_valid_ff <= in_valid;
         if (adv_d) d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_c) begin
         c_meta_ff   <= c_meta_in;
         c_width_ff  <= in_width;
         c_offset_ff <= in_offset;
         c_side_ff   <= low_half ? in_offset : rest;
      end
      if (adv_d) begin
         d_meta_ff <= c_meta_ff;
         d_num_ff  <= c_meta_ff.quad ? side_sq  : PROD_W'(c_offset_ff);
         d_den_ff  <= c_meta_ff.quad ? width_sq : PROD_W'(c_width_ff);
      end
   end

   assign out_valid = d_valid_ff;
   assign out_meta  = d_meta_ff;
   assign out_num   = d_num_ff;
   assign out_den   = d_den_ff;

endmodule

[design/rbc_divider.sv]
module rbc_divider #(
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  rbc_pkg::rbc_meta_type         in_meta,
   input  logic [rbc_pkg::PROD_W-1:0]    in_num,
   input  logic [rbc_pkg::PROD_W-1:0]    in_den,
   output logic                          out_valid,
   input  logic                          out_ready,
   output rbc_pkg::rbc_meta_type         out_meta,
   output logic [WEIGHT_FRAC_BITS:0]     out_quo
);
   import rbc_pkg::*;

   localparam int STEPS = WEIGHT_FRAC_BITS + 1;

   logic              v_ff   [STEPS];
   logic              adv    [STEPS];
   logic [PROD_W-1:0] rem_ff [STEPS];
   logic [PROD_W-1:0] den_ff [STEPS];
   logic [STEPS-1:0]  quo_ff [STEPS];
   rbc_meta_type      meta_ff[STEPS];

   // one restoring step per stage, one quotient bit each
   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic              src_valid;
      logic [PROD_W-1:0] src_rem;
      logic [PROD_W-1:0] src_den;
      logic [STEPS-1:0]  src_quo;
      rbc_meta_type      src_meta;
      logic [PROD_W:0]   shifted;
      logic              take;
      logic [PROD_W-1:0] rem_in;

      if (j == 0) begin : g_head
         assign src_valid = in_valid;
         assign src_rem   = in_num;
         assign src_den   = in_den;
         assign src_quo   = '0;
         assign src_meta  = in_meta;
      end else begin : g_body
         assign src_valid = v_ff[j-1];
         assign src_rem   = rem_ff[j-1];
         assign src_den   = den_ff[j-1];
         assign src_quo   = quo_ff[j-1];
         assign src_meta  = meta_ff[j-1];
      end

      if (j == STEPS - 1) begin : g_tail
         assign adv[j] = !v_ff[j] || out_ready;
      end else begin : g_link
         assign adv[j] = !v_ff[j] || adv[j+1];
      end

      assign shifted = {src_rem, 1'b0};
      assign take    = shifted >= {1'b0, src_den};
      assign rem_in  = take ? PROD_W'(shifted - {1'b0, src_den}) : PROD_W'(shifted);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (adv[j]) begin
            v_ff[j] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[j]) begin
            rem_ff[j]  <= rem_in;
            den_ff[j]  <= src_den;
            quo_ff[j]  <= {src_quo[STEPS-2:0], take};
            meta_ff[j] <= src_meta;
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[STEPS-1];
   assign out_meta  = meta_ff[STEPS-1];
   assign out_quo   = quo_ff[STEPS-1];

endmodule

[design/regime_blend_classifier_top.sv]
// Regime blend classifier. Each req beat carries one signed Q16.16 sample; each
// rsp beat returns the regime it falls in, or, when it lies in the half-open gap
// [upper(i-1), lower(i)) between two neighbors, both neighbor labels with
// weights of WEIGHT_FRAC_BITS fraction bits that always sum to exactly one.
// The block takes one beat per clock and keeps doing so while rsp is stalled,
// until every stage holds a beat. From req acceptance to rsp_valid a
// beat passes two classify stages, a select stage, a squaring stage, one
// restoring-division stage per quotient bit (WEIGHT_FRAC_BITS + 1 of them,
// which set the depth), and the output register. Program the csr registers
// only while no beat is in flight.
module regime_blend_classifier_top #(
   parameter int MAX_REGIMES      = 4,
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [rbc_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rbc_pkg::LABEL_W-1:0]           rsp_first_regime,
   output logic [WEIGHT_FRAC_BITS:0]             rsp_first_weight,
   output logic [rbc_pkg::LABEL_W-1:0]           rsp_second_regime,
   output logic [WEIGHT_FRAC_BITS:0]             rsp_second_weight,
   output logic                                  rsp_blended,
   input  logic                                  csr_wr_en,
   input  logic [rbc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [rbc_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import rbc_pkg::*;

   localparam logic [WEIGHT_FRAC_BITS:0] WEIGHT_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

   // configuration registers
   logic [COUNT_W-1:0]                   count_ff;
   logic                                 mode_ff;
   logic [MAX_REGIMES-1:0][BOUND_W-1:0]  bounds_ff;

   // classify -> shape
   logic                cls_valid;
   logic                cls_ready;
   rbc_meta_type        cls_meta;
   logic [SAMPLE_W-1:0] cls_width;
   logic [SAMPLE_W-1:0] cls_offset;

   // shape -> divider
   logic                shp_valid;
   logic                shp_ready;
   rbc_meta_type        shp_meta;
   logic [PROD_W-1:0]   shp_num;
   logic [PROD_W-1:0]   shp_den;

   // divider -> output register
   logic                      div_valid;
   logic                      div_ready;
   rbc_meta_type              div_meta;
   logic [WEIGHT_FRAC_BITS:0] div_quo;

   logic [WEIGHT_FRAC_BITS:0] first_weight_in;
   logic [WEIGHT_FRAC_BITS:0] second_weight_in;
   logic [LABEL_W-1:0]        second_regime_in;

   logic                      rsp_valid_ff;
   logic [LABEL_W-1:0]        first_regime_ff;
   logic [WEIGHT_FRAC_BITS:0] first_weight_ff;
   logic [LABEL_W-1:0]        second_regime_ff;
   logic [WEIGHT_FRAC_BITS:0] second_weight_ff;
   logic                      blended_ff;

   // csr writes land at once; indexes past the bound slots drop silently
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= COUNT_W'(1);
         mode_ff   <= 1'b0;
         bounds_ff <= '0;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_REGIME_COUNT) count_ff <= csr_wdata[COUNT_W-1:0];
         if (csr_index == CSR_BLEND_MODE)   mode_ff  <= csr_wdata[0];
         for (int k = 0; k < MAX_REGIMES; k++) begin
            if (csr_index == CSR_INDEX_W'(CSR_BOUNDS_0 + k)) bounds_ff[k] <= csr_wdata;
         end
      end
   end

   // segment search, then gap width and offset from the gap start
   rbc_classify #(
      .MAX_REGIMES(MAX_REGIMES)
   ) u_classify (
      .clock        (clock),
      .reset        (reset),
      .regime_count (count_ff),
      .regime_bounds(bounds_ff),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_sample    (req_sample),
      .out_valid    (cls_valid),
      .out_ready    (cls_ready),
      .out_meta     (cls_meta),
      .out_width    (cls_width),
      .out_offset   (cls_offset)
   );

   // pick the half of the gap and form numerator and denominator
   rbc_shape u_shape (
      .clock     (clock),
      .reset     (reset),
      .blend_mode(mode_ff),
      .in_valid  (cls_valid),
      .in_ready  (cls_ready),
      .in_meta   (cls_meta),
      .in_width  (cls_width),
      .in_offset (cls_offset),
      .out_valid (shp_valid),
      .out_ready (shp_ready),
      .out_meta  (shp_meta),
      .out_num   (shp_num),
      .out_den   (shp_den)
   );

   // fraction num/den with WEIGHT_FRAC_BITS + 1 quotient bits
   rbc_divider #(
      .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .in_valid (shp_valid),
      .in_ready (shp_ready),
      .in_meta  (shp_meta),
      .in_num   (shp_num),
      .in_den   (shp_den),
      .out_valid(div_valid),
      .out_ready(div_ready),
      .out_meta (div_meta),
      .out_quo  (div_quo)
   );

   // Linear mode divides with one extra quotient bit; drop it to get the
   // WEIGHT_FRAC_BITS result. In the quadratic mode the quotient already
   // carries the factor of two and belongs to the far neighbor.
   always_comb begin
      first_weight_in  = WEIGHT_ONE;
      second_weight_in = '0;
      if (div_meta.gap) begin
         if (!div_meta.quad) begin
            second_weight_in = {1'b0, div_quo[WEIGHT_FRAC_BITS:1]};
            first_weight_in  = WEIGHT_ONE - second_weight_in;
         end else if (div_meta.low_half) begin
            second_weight_in = div_quo;
            first_weight_in  = WEIGHT_ONE - div_quo;
         end else begin
            first_weight_in  = div_quo;
            second_weight_in = WEIGHT_ONE - div_quo;
         end
      end
   end

   assign second_regime_in = div_meta.gap ? div_meta.label + LABEL_W'(1) : div_meta.label;

   // output register: advance when empty or when the beat is taken
   assign div_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_ready) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready) begin
         first_regime_ff  <= div_meta.label;
         first_weight_ff  <= first_weight_in;
         second_regime_ff <= second_regime_in;
         second_weight_ff <= second_weight_in;
         blended_ff       <= div_meta.gap;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_first_regime  = first_regime_ff;
   assign rsp_first_weight  = first_weight_ff;
   assign rsp_second_regime = second_regime_ff;
   assign rsp_second_weight = second_weight_ff;
   assign rsp_blended       = blended_ff;

   // blended weights split exactly one between the two neighbors
   a_weight_sum : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_blended) |->
         ((WEIGHT_FRAC_BITS + 2)'(rsp_first_weight) + (WEIGHT_FRAC_BITS + 2)'(rsp_second_weight)
            == (WEIGHT_FRAC_BITS + 2)'(WEIGHT_ONE)))
      else $error("blended weights do not sum to one");

   // a plain segment names one regime with full weight
   a_plain_seg : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_blended) |->
         (rsp_second_regime == rsp_first_regime && rsp_first_weight == WEIGHT_ONE &&
          rsp_second_weight == '0))
      else $error("unblended result is not a single full-weight regime");

   // a gap always sits between adjacent regimes
   a_gap_neighbors : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_blended) |->
         (rsp_second_regime == rsp_first_regime + LABEL_W'(1)))
      else $error("gap neighbors are not adjacent");

endmodule

[tb/regime_blend_classifier_top_tb.sv]
`timescale 1ns / 1ps

module regime_blend_classifier_top_tb;
   import rbc_pkg::*;

   localparam int MAX_REGIMES      = 4;
   localparam int WEIGHT_FRAC_BITS = 16;
   localparam int BOUND_SLOTS      = 4;

   localparam logic [WEIGHT_FRAC_BITS:0] UNIT_WEIGHT = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

   // indexes past the bounds registers; writes there must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = CSR_BOUNDS_0 + CSR_INDEX_W'(BOUND_SLOTS);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = CSR_SPARE_A + CSR_INDEX_W'(1);

   localparam longint Q16_MAX = (longint'(1) << 31) - 1;
   localparam longint Q16_MIN = -(longint'(1) << 31);

   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 108;
   localparam int CALM_PHASE      = 6;    // neither side idles in this phase
   localparam int HOLD_AT_RESULT  = 400;  // lands mid-phase while the sender keeps offering
   localparam int HOLD_CYCLES     = 100;  // well past the pipeline depth
   localparam int STALL_LIMIT     = 3000;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [LABEL_W-1:0]        first_regime;
      logic [WEIGHT_FRAC_BITS:0] first_weight;
      logic [LABEL_W-1:0]        second_regime;
      logic [WEIGHT_FRAC_BITS:0] second_weight;
      logic                      blended;
   } regime_pick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [SAMPLE_W-1:0]          req_sample = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [LABEL_W-1:0]                  rsp_first_regime;
   logic [WEIGHT_FRAC_BITS:0]           rsp_first_weight;
   logic [LABEL_W-1:0]                  rsp_second_regime;
   logic [WEIGHT_FRAC_BITS:0]           rsp_second_weight;
   logic                                rsp_blended;
   logic                                csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]              csr_index = '0;
   logic [CSR_DATA_W-1:0]               csr_wdata = '0;

   // shadow of the register file, at its reset values
   logic [COUNT_W-1:0] cfg_count = COUNT_W'(1);
   logic               cfg_quad  = 1'b0;
   logic [BOUND_W-1:0] cfg_bounds [BOUND_SLOTS] = '{default: '0};

   logic [SAMPLE_W-1:0] sample_backlog [$];
   regime_pick_type     pending_picks [$];

   int     send_idle_pct = 15;
   int     recv_idle_pct = 15;
   longint sample_span   = 1;
   int     results_seen  = 0;
   int     hold_left     = 0;
   bit     hold_done     = 1'b0;
   int     fail_count    = 0;
   int     quiet_cycles  = 0;
   int     phase;

   regime_blend_classifier_top #(
      .MAX_REGIMES      (MAX_REGIMES),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_first_regime  (rsp_first_regime),
      .rsp_first_weight  (rsp_first_weight),
      .rsp_second_regime (rsp_second_regime),
      .rsp_second_weight (rsp_second_weight),
      .rsp_blended       (rsp_blended),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // floor(num * 2^bits / den) by restoring division; zero unless num < den
   function automatic logic [WEIGHT_FRAC_BITS:0] scaled_ratio(input logic [63:0] num,
                                                              input logic [63:0] den,
                                                              input int bits);
      logic [64:0]               rem;
      logic [WEIGHT_FRAC_BITS:0] quo;
      if (den == 0 || num >= den) return '0;
      rem = {1'b0, num};
      quo = '0;
      repeat (bits) begin
         rem = {rem[63:0], 1'b0};
         quo = {quo[WEIGHT_FRAC_BITS-1:0], 1'b0};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[0] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Expected labels and weights for one sample under the shadow registers.
   function automatic regime_pick_type classify_sample(
      input logic signed [SAMPLE_W-1:0] sample);
      int                 used, label, i;
      bit                 in_gap;
      logic signed [31:0] ub, lb, gap_lo, gap_hi;
      logic [63:0]        width, offset, tail;
      regime_pick_type    pick;
      used = int'(cfg_count);
      if (used < 1) used = 1;
      if (used > MAX_REGIMES) used = MAX_REGIMES;
      label  = 0;
      in_gap = 1'b0;
      gap_lo = '0;
      gap_hi = '0;
      // walk the segment starts in order; the last one not above the sample wins
      for (i = 1; i < used; i++) begin
         ub = cfg_bounds[2'(i - 1)][63:32];
         lb = cfg_bounds[2'(i)][31:0];
         if (ub < lb && sample >= ub) begin
            in_gap = 1'b1;
            label  = i - 1;
            gap_lo = ub;
            gap_hi = lb;
         end
         if (sample >= lb) begin
            in_gap = 1'b0;
            label  = i;
         end
      end
      pick.first_regime = LABEL_W'(label);
      pick.blended      = in_gap;
      if (!in_gap) begin
         pick.first_weight  = UNIT_WEIGHT;
         pick.second_regime = LABEL_W'(label);
         pick.second_weight = '0;
         return pick;
      end
      width  = 64'(longint'(gap_hi) - longint'(gap_lo));
      offset = 64'(longint'(sample) - longint'(gap_lo));
      pick.second_regime = LABEL_W'(label + 1);
      if (!cfg_quad) begin
         pick.second_weight = scaled_ratio(offset, width, WEIGHT_FRAC_BITS);
         pick.first_weight  = UNIT_WEIGHT - pick.second_weight;
      end else if ((offset << 1) <= width) begin
         pick.second_weight = scaled_ratio(offset * offset, width * width, WEIGHT_FRAC_BITS + 1);
         pick.first_weight  = UNIT_WEIGHT - pick.second_weight;
      end else begin
         tail = width - offset;
         pick.first_weight  = scaled_ratio(tail * tail, width * width, WEIGHT_FRAC_BITS + 1);
         pick.second_weight = UNIT_WEIGHT - pick.first_weight;
      end
      return pick;
   endfunction

   function automatic logic [31:0] clamp_q16(input longint v);
      if (v > Q16_MAX) return 32'h7FFF_FFFF;
      if (v < Q16_MIN) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // Write one register and track it in the shadow.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [63:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      if (index == CSR_REGIME_COUNT) cfg_count = data[COUNT_W-1:0];
      else if (index == CSR_BLEND_MODE) cfg_quad = data[0];
      else if (index >= CSR_BOUNDS_0 && index < CSR_SPARE_A)
         cfg_bounds[2'(index - CSR_BOUNDS_0)] = data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Hold until every queued sample is sent and every result is back.
   task automatic settle();
      do @(negedge clock);
      while (sample_backlog.size() != 0 || req_valid || pending_picks.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Build a mostly sorted map of random scale: gaps, touching and
   // overlapping bounds, the odd unsorted pair and the odd junk register.
   task automatic program_random_map();
      longint      cursor, step;
      logic [31:0] lo, hi;
      logic [63:0] word;
      int          shape, k, count_pick;
      step   = longint'(1) << $urandom_range(1, 30);
      cursor = -3 * step + longint'($urandom_range(0, int'(step)));
      count_pick = $urandom_range(0, 9);
      word = {$urandom, $urandom};
      if (count_pick < 6) word[COUNT_W-1:0] = 3'd4;
      else if (count_pick == 6) word[COUNT_W-1:0] = 3'd3;
      else if (count_pick == 7) word[COUNT_W-1:0] = 3'd2;
      else if (count_pick == 8) word[COUNT_W-1:0] = COUNT_W'($urandom_range(0, 1));
      else word[COUNT_W-1:0] = COUNT_W'($urandom_range(5, 7));
      write_reg(CSR_REGIME_COUNT, word);
      write_reg(CSR_BLEND_MODE, {$urandom, $urandom});
      for (k = 0; k < BOUND_SLOTS; k++) begin
         lo = clamp_q16(cursor);
         cursor += longint'($urandom_range(0, int'(step)));
         hi = clamp_q16(cursor);
         shape = $urandom_range(0, 9);
         if (shape < 6) cursor += longint'($urandom_range(1, int'(step)));
         else if (shape == 8) cursor -= longint'($urandom_range(1, int'(step)));
         else if (shape == 9) cursor -= longint'($urandom_range(int'(step), int'(2 * step)));
         if ($urandom_range(0, 7) == 0)
            write_reg(CSR_BOUNDS_0 + CSR_INDEX_W'(k), {$urandom, $urandom});
         else
            write_reg(CSR_BOUNDS_0 + CSR_INDEX_W'(k), {hi, lo});
      end
      sample_span = step;
   endtask

   // Aim most samples at the programmed bounds: exact hits, one off, and spread
   // over one map step either side; the rest are raw 32-bit values.
   task automatic queue_random_samples(input int n);
      int          pick;
      logic [63:0] slot;
      longint      base, offset;
      repeat (n) begin
         pick = $urandom_range(0, 9);
         slot = cfg_bounds[2'($urandom_range(0, BOUND_SLOTS - 1))];
         base = $urandom_range(0, 1) ? longint'($signed(slot[63:32]))
                                     : longint'($signed(slot[31:0]));
         if (pick < 2) begin
            sample_backlog.push_back($urandom);
         end else begin
            if (pick == 2) offset = 0;
            else if (pick == 3) offset = $urandom_range(0, 1) ? 1 : -1;
            else offset = longint'($urandom_range(0, int'(2 * sample_span))) - sample_span;
            sample_backlog.push_back(clamp_q16(base + offset));
         end
      end
   endtask

   // Driver: offer the next sample, keep valid and payload steady until taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid  <= 1'b1;
            req_sample <= sample_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predict on each accepted sample, check each accepted result,
   // and drive rsp_ready with random stalls plus one long hold-off.
   always @(posedge clock) begin
      regime_pick_type got, want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready) pending_picks.push_back(classify_sample(req_sample));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_first_regime, rsp_first_weight, rsp_second_regime,
                   rsp_second_weight, rsp_blended};
            results_seen++;
            if (pending_picks.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: result with nothing outstanding: %s %0d/%0d %s %0d/%0d %s %0b",
                           $realtime, "regime", got.first_regime, got.second_regime,
                           "weight", got.first_weight, got.second_weight,
                           "blended", got.blended);
            end else begin
               want = pending_picks.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("%0t: result %0d mismatch: regime %0d/%0d weight %0d/%0d %s %0b",
                              $realtime, results_seen, got.first_regime, got.second_regime,
                              got.first_weight, got.second_weight, "blended", got.blended);
                     $display("   want regime %0d/%0d weight %0d/%0d blended %0b",
                              want.first_regime, want.second_regime,
                              want.first_weight, want.second_weight, want.blended);
                  end
               end
            end
         end
         // hold off once so the pipeline fills and backs up into req_ready
         if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: drop out if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("regime_blend_classifier_top_tb: errors");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset map: one regime covers everything
      sample_backlog.push_back(32'h8000_0000);
      sample_backlog.push_back(32'h0000_0000);
      sample_backlog.push_back(32'h7FFF_FFFF);
      settle();

      // four regimes: gap [-2.0,-1.0) between 0 and 1, touching bounds
      // between 1 and 2, overlap between 2 and 3; unused halves hold junk
      write_reg(CSR_REGIME_COUNT, 64'd4);
      write_reg(CSR_BLEND_MODE, 64'd0);
      write_reg(CSR_BOUNDS_0,                  {32'hFFFE_0000, 32'h1234_5678});
      write_reg(CSR_BOUNDS_0 + CSR_INDEX_W'(1), {32'h0001_0000, 32'hFFFF_0000});
      write_reg(CSR_BOUNDS_0 + CSR_INDEX_W'(2), {32'h0003_0000, 32'h0001_0000});
      write_reg(CSR_BOUNDS_0 + CSR_INDEX_W'(3), {32'hDEAD_BEEF, 32'h0002_8000});
      write_reg(CSR_SPARE_A, {$urandom, $urandom});
      write_reg(CSR_SPARE_B, {$urandom, $urandom});
      sample_backlog.push_back(32'hFFFE_0000);  // gap start
      sample_backlog.push_back(32'hFFFF_0000);  // lower bound of regime 1
      sample_backlog.push_back(32'hFFFE_FFFF);  // last point of the gap
      sample_backlog.push_back(32'hFFFE_8000);  // gap midpoint
      sample_backlog.push_back(32'h0001_0000);  // touching bounds
      sample_backlog.push_back(32'h0002_8000);  // overlapped lower bound
      sample_backlog.push_back(32'h0002_7FFF);
      sample_backlog.push_back(32'h8000_0000);
      sample_backlog.push_back(32'h7FFF_FFFF);
      settle();

      // same gap, two-piece quadratic, both halves and the split point
      write_reg(CSR_BLEND_MODE, 64'd1);
      sample_backlog.push_back(32'hFFFE_8000);
      sample_backlog.push_back(32'hFFFE_8001);
      sample_backlog.push_back(32'hFFFE_0001);
      sample_backlog.push_back(32'hFFFE_FFFF);
      settle();

      // widest possible gap, spanning the whole sample range
      write_reg(CSR_REGIME_COUNT, 64'd2);
      write_reg(CSR_BOUNDS_0,                  {32'h8000_0000, 32'h0000_0000});
      write_reg(CSR_BOUNDS_0 + CSR_INDEX_W'(1), {32'h0000_0000, 32'h7FFF_FFFF});
      sample_backlog.push_back(32'h8000_0000);
      sample_backlog.push_back(32'h7FFF_FFFE);
      sample_backlog.push_back(32'h0000_0000);
      sample_backlog.push_back(32'h7FFF_FFFF);
      sample_backlog.push_back(32'hFFFF_FFFF);
      settle();

      // a count of zero acts as one regime, above four as four
      write_reg(CSR_REGIME_COUNT, 64'd0);
      sample_backlog.push_back(32'h7FFF_FFFF);
      sample_backlog.push_back(32'h0000_0000);
      settle();
      write_reg(CSR_REGIME_COUNT, 64'd7);
      sample_backlog.push_back(32'h7FFF_FFFF);
      sample_backlog.push_back(32'h8000_0000);
      settle();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         send_idle_pct = (phase == CALM_PHASE) ? 0 : 15;
         recv_idle_pct = (phase == CALM_PHASE) ? 0 : 15;
         program_random_map();
         queue_random_samples(ITEMS_PER_PHASE);
         settle();
      end

      // let any stray late result show up before the verdict
      repeat (30) @(posedge clock);
      if (fail_count == 0 && pending_picks.size() == 0)
         $display("regime_blend_classifier_top_tb: clean");
      else
         $display("regime_blend_classifier_top_tb: errors");
      $finish;
   end

endmodule
